FILE: rtl/core/fbr_pkg.sv
// Package: shared types, codes and the CRC-8 step for the framed block receiver.
`timescale 1ns / 1ps
package fbr_pkg;

    localparam logic [7:0] BYTE_START = 8'hE0;
    localparam logic [7:0] BYTE_END   = 8'hE1;
    localparam logic [7:0] BYTE_ACK   = 8'hE2;
    localparam logic [7:0] BYTE_NAK   = 8'hE3;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_TOP    = 8'h80;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_START   = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;
    localparam logic [1:0] EV_ABANDON = 2'd3;

    // run = 1: release len buffered bytes; otherwise one result from reply/evt
    typedef struct packed {
        logic       run;
        logic [7:0] len;
        logic [1:0] reply;
        logic [1:0] evt;
        logic [7:0] seq;
    } cmd_t;

    typedef struct packed {
        logic running;
        logic run_done;
    } back_stat_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/fbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fbr_cmd_fifo.sv
// Two-entry command queue between the front parser and the back release unit.
`timescale 1ns / 1ps
module fbr_cmd_fifo
    import fbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

FILE: rtl/core/fbr_front.sv
// Front end: link byte parser, CRC update, payload buffering and command issue.
`timescale 1ns / 1ps
module fbr_front
    import fbr_pkg::*;
#(
    parameter int MAX_BLOCK = 64,
    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    rx_byte,
    input  logic          edge_timeout,
    input  logic          fifo_full,
    input  back_stat_t    back_stat,
    output logic          cmd_push,
    output cmd_t          cmd,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata
);

    typedef enum logic [3:0] {
        PH_TOP  = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CRC  = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       in_tx_reg, in_tx_next;
    logic [7:0] seq_reg, seq_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] rcvd_reg, rcvd_next;
    logic [7:0] crc_reg, crc_next;
    logic       ovf_reg, ovf_next;
    logic       pend_reg, pend_next;
    logic       acc;
    logic       is_ctrl;
    logic [7:0] rcvd_inc;

    assign full     = fifo_full || ((phase_reg == PH_DATA) && pend_reg);
    assign acc      = push && !full;
    assign is_ctrl  = (rx_byte == BYTE_START) || (rx_byte == BYTE_END) ||
                      (rx_byte == BYTE_ACK) || (rx_byte == BYTE_NAK);
    assign rcvd_inc = rcvd_reg + 8'd1;

    assign ram_waddr = rcvd_reg[AW-1:0];
    assign ram_wdata = rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        in_tx_next = in_tx_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        rcvd_next  = rcvd_reg;
        crc_next   = crc_reg;
        ovf_next   = ovf_reg;
        cmd_push   = 1'b0;
        cmd        = '{run: 1'b0, len: len_reg, reply: REPLY_NONE, evt: EV_NONE,
                       seq: seq_reg};
        ram_we     = 1'b0;
        if (acc)
        begin
            if (edge_timeout)
            begin
                if (phase_reg != PH_TOP)
                begin
                    phase_next = PH_TOP;
                    cmd_push   = 1'b1;
                    cmd.evt    = EV_ABANDON;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        len_next   = rx_byte;
                        rcvd_next  = 8'd0;
                        crc_next   = CRC_INIT;
                        ovf_next   = (rx_byte > 8'(MAX_BLOCK));
                        phase_next = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        crc_next  = crc8_step(crc_reg, rx_byte);
                        ram_we    = (rcvd_reg < 8'(MAX_BLOCK));
                        rcvd_next = rcvd_inc;
                        if (rcvd_inc == len_reg)
                            phase_next = PH_CRC;
                    end
                    PH_CRC:
                    begin
                        phase_next = PH_TOP;
                        cmd_push   = 1'b1;
                        if ((rx_byte == crc_reg) && !ovf_reg)
                        begin
                            if (len_reg == 8'd0)
                                cmd.reply = REPLY_ACK;
                            else
                                cmd.run = 1'b1;
                        end
                        else
                            cmd.reply = REPLY_NAK;
                    end
                    PH_TOP:
                    begin
                        if (rx_byte == BYTE_START)
                        begin
                            in_tx_next = 1'b1;
                            cmd_push   = 1'b1;
                            cmd.evt    = EV_START;
                            cmd.seq    = 8'd0;
                        end
                        else if (rx_byte == BYTE_END)
                        begin
                            in_tx_next = 1'b0;
                            cmd_push   = 1'b1;
                            cmd.evt    = EV_END;
                            cmd.seq    = 8'd0;
                        end
                        else if (in_tx_reg && !is_ctrl)
                        begin
                            seq_next   = rx_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    default:
                        phase_next = PH_TOP;
                endcase
            end
        end
    end

    // buffer is owned by the back end from issue of a release until its last read
    always_comb
    begin
        pend_next = pend_reg;
        if (back_stat.run_done)
            pend_next = 1'b0;
        if (cmd_push && cmd.run)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOP;
            in_tx_reg <= 1'b0;
            seq_reg   <= 8'd0;
            len_reg   <= 8'd0;
            rcvd_reg  <= 8'd0;
            crc_reg   <= CRC_INIT;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            in_tx_reg <= in_tx_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            rcvd_reg  <= rcvd_next;
            crc_reg   <= crc_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: rtl/core/fbr_back.sv
// Back end: turns commands into result items, reading released blocks from the buffer.
`timescale 1ns / 1ps
module fbr_back
    import fbr_pkg::*;
#(
    parameter int MAX_BLOCK = 64,
    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_pop,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata,
    output back_stat_t    back_stat,
    output logic          empty,
    input  logic          pop,
    output logic          data_valid,
    output logic [7:0]    payload_byte,
    output logic [1:0]    reply,
    output logic [1:0]    event_res,
    output logic [7:0]    block_seq,
    output logic          last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_WR   = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] seq_reg, seq_next;
    logic       ov_reg, ov_next;
    logic       dv_reg, dv_next;
    logic [7:0] pb_reg, pb_next;
    logic [1:0] rep_reg, rep_next;
    logic [1:0] ev_reg, ev_next;
    logic [7:0] bs_reg, bs_next;
    logic       last_reg, last_next;
    logic       slot_free;
    logic       run_last;

    assign slot_free = !ov_reg || pop;
    assign run_last  = (idx_reg == (len_reg - 8'd1));
    assign ram_raddr = idx_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        seq_next   = seq_reg;
        ov_next    = ov_reg && !pop;
        dv_next    = dv_reg;
        pb_next    = pb_reg;
        rep_next   = rep_reg;
        ev_next    = ev_reg;
        bs_next    = bs_reg;
        last_next  = last_reg;
        cmd_pop    = 1'b0;
        ram_re     = 1'b0;
        back_stat  = '{running: (state_reg != S_IDLE), run_done: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.run)
                    begin
                        cmd_pop    = 1'b1;
                        idx_next   = 8'd0;
                        len_next   = cmd.len;
                        seq_next   = cmd.seq;
                        state_next = S_RD;
                    end
                    else if (slot_free)
                    begin
                        cmd_pop   = 1'b1;
                        ov_next   = 1'b1;
                        dv_next   = 1'b0;
                        pb_next   = 8'd0;
                        rep_next  = cmd.reply;
                        ev_next   = cmd.evt;
                        bs_next   = cmd.seq;
                        last_next = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    dv_next   = 1'b1;
                    pb_next   = ram_rdata;
                    rep_next  = run_last ? REPLY_ACK : REPLY_NONE;
                    ev_next   = EV_NONE;
                    bs_next   = seq_reg;
                    last_next = run_last;
                    if (run_last)
                    begin
                        back_stat.run_done = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 8'd1;
                        state_next = S_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        seq_reg  <= seq_next;
        dv_reg   <= dv_next;
        pb_reg   <= pb_next;
        rep_reg  <= rep_next;
        ev_reg   <= ev_next;
        bs_reg   <= bs_next;
        last_reg <= last_next;
    end

    assign empty        = !ov_reg;
    assign data_valid   = dv_reg;
    assign payload_byte = pb_reg;
    assign reply        = rep_reg;
    assign event_res    = ev_reg;
    assign block_seq    = bs_reg;
    assign last         = last_reg;

endmodule

FILE: rtl/core/framed_block_receiver_crc8.sv
// Top level of the framed block receiver with CRC-8 check.
`timescale 1ns / 1ps
// The front end takes one link byte per cycle while full is low, checks framing,
// updates the CRC-8 (poly 0x07, init 0) and buffers up to MAX_BLOCK payload
// bytes in a RAM. Each event, reply or accepted block goes as a command through
// a two-entry queue to the back end, which hands out result items through a
// one-item output register. A single-result command is loaded straight into it;
// an accepted block goes by a command pop, then a buffer read and an output load
// per byte. While a block is being released the front end holds off bytes in the
// payload phase of the next block (full stays high) until the last buffered byte
// has been read; full is also high while the command queue is full.
module framed_block_receiver_crc8
    import fbr_pkg::*;
#(
    parameter int MAX_BLOCK = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       edge_timeout,
    output logic       empty,
    input  logic       pop,
    output logic       data_valid,
    output logic [7:0] payload_byte,
    output logic [1:0] reply,
    output logic [1:0] event_res,
    output logic [7:0] block_seq,
    output logic       last
);

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    logic          cmd_push;
    cmd_t          cmd_in;
    cmd_t          cmd_out;
    logic          fifo_full;
    logic          fifo_empty;
    logic          cmd_pop;
    back_stat_t    back_stat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    fbr_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .edge_timeout (edge_timeout),
        .fifo_full    (fifo_full),
        .back_stat    (back_stat),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    fbr_cmd_fifo u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .full   (fifo_full),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_out),
        .empty  (fifo_empty)
    );

    fbr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BLOCK)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbr_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!fifo_empty),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .back_stat    (back_stat),
        .empty        (empty),
        .pop          (pop),
        .data_valid   (data_valid),
        .payload_byte (payload_byte),
        .reply        (reply),
        .event_res    (event_res),
        .block_seq    (block_seq),
        .last         (last)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_full)
        else $error("command issued into a full queue");

    a_buf_owned_by_back: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !back_stat.running)
        else $error("buffer written while a block is being released");

    a_data_item_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && data_valid) |-> (event_res == EV_NONE && reply != REPLY_NAK))
        else $error("data item carries an event or NAK");

    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reply == REPLY_ACK) |-> last)
        else $error("ACK on an item that is not last");

endmodule
